// File: rtl/lfs_pkg.sv
`default_nettype none

package lfs_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int THR_W       = 2 * SAMPLE_BITS;
  localparam int NUM_CH      = 8;
  localparam int CH_IDX_W    = $clog2(NUM_CH);
  localparam int DUTY_W      = 7;

  localparam int BASE_DUTY = 20;
  localparam int MAX_DUTY  = 100;
  localparam int NUDGE     = 5;
  localparam int DUTY_CAP  = 100;

  localparam logic [THR_W-1:0] THR_RESET [NUM_CH] = '{
    THR_W'(12200717), THR_W'(12761999), THR_W'(13093852), THR_W'(8996902),
    THR_W'(11442781), THR_W'(12630897), THR_W'(12208911), THR_W'(8808442)
  };

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_e;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } steer_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > DUTY_CAP) begin
      return DUTY_W'(DUTY_CAP);
    end
    return DUTY_W'(v);
  endfunction

  // Fixed duty pairs, settled at elaboration
  localparam logic [DUTY_W-1:0] DUTY_STRAIGHT = clamp_duty(BASE_DUTY);
  localparam logic [DUTY_W-1:0] DUTY_NUDGE_LO = clamp_duty(BASE_DUTY - NUDGE);
  localparam logic [DUTY_W-1:0] DUTY_NUDGE_HI = clamp_duty(BASE_DUTY + NUDGE);
  localparam logic [DUTY_W-1:0] DUTY_SOFT_IN  = clamp_duty(BASE_DUTY - BASE_DUTY / 2);
  localparam logic [DUTY_W-1:0] DUTY_SOFT_OUT = clamp_duty(BASE_DUTY + MAX_DUTY / 2);
  localparam logic [DUTY_W-1:0] DUTY_HARD_IN  = clamp_duty(0);
  localparam logic [DUTY_W-1:0] DUTY_MID_OUT  = clamp_duty(BASE_DUTY + (2 * MAX_DUTY) / 3);
  localparam logic [DUTY_W-1:0] DUTY_HARD_OUT = clamp_duty(BASE_DUTY + (3 * MAX_DUTY) / 4);
  localparam logic [DUTY_W-1:0] DUTY_SPIN     = clamp_duty(2 * BASE_DUTY);
  localparam logic [DUTY_W-1:0] DUTY_SEARCH   = clamp_duty(BASE_DUTY / 2);

endpackage

`default_nettype wire

// File: rtl/lfs_lane.sv
`default_nettype none

module lfs_lane import lfs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [THR_W-1:0]       thr_i,
  output logic                        bit_d_o
);

  logic                   bit_q;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SAMPLE_BITS-1:0] lo;

  assign hi = thr_i[THR_W-1:SAMPLE_BITS];
  assign lo = thr_i[SAMPLE_BITS-1:0];

  // Turn on above high, off below low, otherwise hold
  always_comb begin
    bit_d_o = bit_q;
    if (!bit_q && (sample_i > hi)) begin
      bit_d_o = 1'b1;
    end else if (bit_q && (sample_i < lo)) begin
      bit_d_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (en_i) begin
      bit_q <= bit_d_o;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lfs_steer.sv
`default_nettype none

module lfs_steer import lfs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [NUM_CH-1:0] line_i,
  output steer_t                 steer_o
);

  turn_e last_turn_q;
  turn_e last_turn_d;

  always_comb begin
    last_turn_d = last_turn_q;
    steer_o     = '{left_duty: DUTY_SEARCH, right_duty: DUTY_SEARCH};
    priority if (line_i[3] || line_i[4]) begin
      last_turn_d = TURN_NONE;
      priority if (line_i[3] && !line_i[4]) begin
        steer_o = '{left_duty: DUTY_NUDGE_LO, right_duty: DUTY_NUDGE_HI};
      end else if (line_i[4] && !line_i[3]) begin
        steer_o = '{left_duty: DUTY_NUDGE_HI, right_duty: DUTY_NUDGE_LO};
      end else begin
        steer_o = '{left_duty: DUTY_STRAIGHT, right_duty: DUTY_STRAIGHT};
      end
    end else if (|line_i[2:0]) begin
      last_turn_d = TURN_LEFT;
      priority if (line_i[2]) begin
        steer_o = '{left_duty: DUTY_SOFT_IN, right_duty: DUTY_SOFT_OUT};
      end else if (line_i[1]) begin
        steer_o = '{left_duty: DUTY_HARD_IN, right_duty: DUTY_MID_OUT};
      end else begin
        steer_o = '{left_duty: DUTY_HARD_IN, right_duty: DUTY_HARD_OUT};
      end
    end else if (|line_i[7:5]) begin
      last_turn_d = TURN_RIGHT;
      priority if (line_i[5]) begin
        steer_o = '{left_duty: DUTY_SOFT_OUT, right_duty: DUTY_SOFT_IN};
      end else if (line_i[6]) begin
        steer_o = '{left_duty: DUTY_MID_OUT, right_duty: DUTY_HARD_IN};
      end else begin
        steer_o = '{left_duty: DUTY_HARD_OUT, right_duty: DUTY_HARD_IN};
      end
    end else begin
      // Line lost: keep spinning toward the last turn, or search straight if there was none
      unique case (last_turn_q)
        TURN_LEFT:  steer_o = '{left_duty: DUTY_HARD_IN, right_duty: DUTY_SPIN};
        TURN_RIGHT: steer_o = '{left_duty: DUTY_SPIN, right_duty: DUTY_HARD_IN};
        default:    steer_o = '{left_duty: DUTY_SEARCH, right_duty: DUTY_SEARCH};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_turn_q <= TURN_NONE;
    end else if (en_i) begin
      last_turn_q <= last_turn_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/line_follow_steering_unit.sv
// Channel  | Handshake                         | Payload
// request  | in_valid_i / in_stall_o           | sample_0_i .. sample_7_i
// result   | out_valid_o / out_stall_i         | left_duty_o, right_duty_o, line_bits_o
// config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// One request per cycle while the input is not stalled; its result shows up in the cycle after acceptance.
// Eight comparator lanes and the priority steering mux are combinational, ahead of the output register.
// Reset clears the on-line bits, the last turn and the output valid, and loads
// the threshold registers with their default values.
// The input stalls only while a result is held in the output register and the
// output side stalls.
`default_nettype none

module line_follow_steering_unit import lfs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_0_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_1_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_2_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_3_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_4_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_5_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_6_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_7_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [DUTY_W-1:0]           left_duty_o,
  output logic [DUTY_W-1:0]           right_duty_o,
  output logic [NUM_CH-1:0]           line_bits_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CH_IDX_W+1:0]    paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [THR_W-1:0]       thr_q [NUM_CH];
  logic [SAMPLE_BITS-1:0] sample [NUM_CH];
  logic [NUM_CH-1:0]      line_d;
  logic                   accept;
  logic                   cfg_wr;
  logic [CH_IDX_W-1:0]    cfg_idx;
  steer_t                 steer;
  logic                   out_valid_q;
  logic [DUTY_W-1:0]      left_duty_q;
  logic [DUTY_W-1:0]      right_duty_q;
  logic [NUM_CH-1:0]      line_bits_q;

  assign sample[0] = sample_0_i;
  assign sample[1] = sample_1_i;
  assign sample[2] = sample_2_i;
  assign sample[3] = sample_3_i;
  assign sample[4] = sample_4_i;
  assign sample[5] = sample_5_i;
  assign sample[6] = sample_6_i;
  assign sample[7] = sample_7_i;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CH_IDX_W+1:2];
  assign prdata  = 32'(thr_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        thr_q[i] <= THR_RESET[i];
      end
    end else if (cfg_wr) begin
      thr_q[cfg_idx] <= pwdata[THR_W-1:0];
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    lfs_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (sample[g]),
      .thr_i    (thr_q[g]),
      .bit_d_o  (line_d[g])
    );
  end

  lfs_steer u_steer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .line_i  (line_d),
    .steer_o (steer)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_duty_q  <= steer.left_duty;
      right_duty_q <= steer.right_duty;
      line_bits_q  <= line_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_duty_q;
  assign right_duty_o = right_duty_q;
  assign line_bits_o  = line_bits_q;

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !accept) |=> !out_valid_o)
    else $error("result repeated after delivery");

  a_duty_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((left_duty_o <= DUTY_W'(DUTY_CAP)) && (right_duty_o <= DUTY_W'(DUTY_CAP))))
    else $error("duty above cap");

endmodule

`default_nettype wire
